// ===== hw/rtl/encoder_band_tuner_core_defines.svh =====
// ----------------------------------------------------------------------------
// encoder_band_tuner_core_defines
// assertion helpers for the encoder band tuner, clocked on i_clk, held off in reset
// ----------------------------------------------------------------------------
`ifndef ENCODER_BAND_TUNER_CORE_DEFINES_SVH
`define ENCODER_BAND_TUNER_CORE_DEFINES_SVH

// same-cycle implication
`define EBT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EBT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ebt_pkg.sv =====
// ----------------------------------------------------------------------------
// ebt_pkg
// shared types, widths, band table and register codes of the band tuner
// ----------------------------------------------------------------------------
package ebt_pkg;

    localparam int FREQ_W  = 24;
    localparam int STEP_W  = 20;
    localparam int TIME_W  = 32;
    localparam int LP_W    = 16;
    localparam int DET_W   = 3;
    localparam int CNT_W   = 4;
    localparam int CFG_W   = 20;
    localparam int CFG_IDX_W = 3;

    localparam int BAND_COUNT_DEF = 4;
    localparam int STEP_COUNT_DEF = 3;
    localparam int BAND_TAB_N     = 4;

    // band table: lower edge, upper edge, default
    localparam logic [FREQ_W-1:0] BAND_LO [BAND_TAB_N] =
        '{24'd3500000, 24'd7000000, 24'd10100000, 24'd14000000};
    localparam logic [FREQ_W-1:0] BAND_HI [BAND_TAB_N] =
        '{24'd4000000, 24'd7200000, 24'd10150000, 24'd14070000};
    localparam logic [FREQ_W-1:0] BAND_DFLT [BAND_TAB_N] =
        '{24'd3700000, 24'd7000000, 24'd10100000, 24'd14000000};

    // register reset values
    localparam logic [LP_W-1:0]   LONG_PRESS_RST = 16'd800;
    localparam logic [DET_W-1:0]  DETENT_RST     = 3'd4;
    localparam logic [STEP_W-1:0] STEP_SMALL_RST = 20'd1000;
    localparam logic [STEP_W-1:0] STEP_MID_RST   = 20'd10000;
    localparam logic [STEP_W-1:0] STEP_LARGE_RST = 20'd100000;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LONG_PRESS = 3'd0,
        CFG_DETENT     = 3'd1,
        CFG_STEP_SMALL = 3'd2,
        CFG_STEP_MID   = 3'd3,
        CFG_STEP_LARGE = 3'd4
    } t_cfg_idx;

    // step selection codes
    localparam logic [1:0] STEP_SEL_SMALL = 2'd0;
    localparam logic [1:0] STEP_SEL_MID   = 2'd1;
    localparam logic [1:0] STEP_SEL_LARGE = 2'd2;

    typedef struct packed {
        logic              phase_a;
        logic              phase_b;
        logic              button_pressed;
        logic [TIME_W-1:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [FREQ_W-1:0] frequency_hz;
        logic [1:0]        band_index;
        logic [1:0]        step_select;
        logic              retune;
        logic              redraw;
    } t_out_item;

    // detent decision from the quadrature decoder
    typedef struct packed {
        logic fire;
        logic up;
    } t_quad_ctl;

    // switch timing decisions
    typedef struct packed {
        logic process;
        logic load_start;
        logic band_adv;
        logic step_adv;
        logic active_nxt;
        logic await_nxt;
    } t_press_ctl;

endpackage

// ===== hw/rtl/ebt_ifs.sv =====
// ----------------------------------------------------------------------------
// ebt_ifs
// valid/ready stream interfaces for encoder samples and tuner results
// ----------------------------------------------------------------------------
interface ebt_in_if;
    logic        valid;
    logic        ready;
    logic        phase_a;
    logic        phase_b;
    logic        button_pressed;
    logic [31:0] now_ms;

    modport source (output valid, phase_a, phase_b, button_pressed, now_ms, input ready);
    modport sink   (input valid, phase_a, phase_b, button_pressed, now_ms, output ready);
endinterface

interface ebt_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] frequency_hz;
    logic [1:0]  band_index;
    logic [1:0]  step_select;
    logic        retune;
    logic        redraw;

    modport source (output valid, frequency_hz, band_index, step_select, retune, redraw,
                    input ready);
    modport sink   (input valid, frequency_hz, band_index, step_select, retune, redraw,
                    output ready);
endinterface

// ===== hw/rtl/ebt_quad.sv =====
// ----------------------------------------------------------------------------
// ebt_quad
// quadrature transition decode and detent counting
// ----------------------------------------------------------------------------
module ebt_quad
    import ebt_pkg::*;
(
    input  logic                    i_process,
    input  logic [1:0]              i_pair,
    input  logic [1:0]              i_last_pair,
    input  logic signed [CNT_W-1:0] i_count,
    input  logic [DET_W-1:0]        i_detent,
    output t_quad_ctl               o_ctl,
    output logic signed [CNT_W-1:0] o_count_nxt,
    output logic [1:0]              o_last_nxt
);

    logic                  change;
    logic [3:0]            code;
    logic                  cnt_up;
    logic                  cnt_dn;
    logic signed [CNT_W:0] cnt_ext;
    logic signed [CNT_W:0] cnt_new;
    logic signed [CNT_W:0] lim;
    logic [DET_W-1:0]      lim_u;

    assign change = i_process && (i_pair != i_last_pair);
    assign code   = {i_last_pair, i_pair};

    // gray-code forward and reverse steps
    always_comb begin
        cnt_up = 1'b0;
        cnt_dn = 1'b0;
        case (code)
            4'd1, 4'd7, 4'd14, 4'd10: cnt_up = 1'b1;
            4'd2, 4'd11, 4'd13, 4'd4: cnt_dn = 1'b1;
            default: ;
        endcase
    end

    // a detent count of zero acts as one
    assign lim_u   = (i_detent == '0) ? DET_W'(1) : i_detent;
    assign lim     = signed'({2'b00, lim_u});
    assign cnt_ext = {i_count[CNT_W-1], i_count};
    assign cnt_new = cnt_up ? cnt_ext + 5'sd1 : (cnt_dn ? cnt_ext - 5'sd1 : cnt_ext);

    assign o_ctl.fire  = change && ((cnt_new >= lim) || (cnt_new <= -lim));
    assign o_ctl.up    = cnt_new > 5'sd0;
    assign o_count_nxt = o_ctl.fire ? '0 : (change ? cnt_new[CNT_W-1:0] : i_count);
    assign o_last_nxt  = change ? i_pair : i_last_pair;

endmodule

// ===== hw/rtl/ebt_press.sv =====
// ----------------------------------------------------------------------------
// ebt_press
// push switch timing: short press, long press and release wait
// ----------------------------------------------------------------------------
module ebt_press
    import ebt_pkg::*;
(
    input  logic              i_pressed,
    input  logic [TIME_W-1:0] i_now,
    input  logic              i_active,
    input  logic [TIME_W-1:0] i_start,
    input  logic              i_await,
    input  logic [LP_W-1:0]   i_long_press,
    output t_press_ctl        o_ctl
);

    logic              waiting;
    logic [TIME_W-1:0] start_eff;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] lp_ext;
    logic              is_long;
    logic              is_short;

    // a release clears the wait and the same sample goes on normally
    assign waiting   = i_await && i_pressed;
    assign start_eff = i_active ? i_start : i_now;
    assign elapsed   = i_now - start_eff;
    assign lp_ext    = {{(TIME_W-LP_W){1'b0}}, i_long_press};
    assign is_long   = elapsed > lp_ext;
    assign is_short  = elapsed < lp_ext;

    always_comb begin
        o_ctl.process    = !waiting;
        o_ctl.load_start = 1'b0;
        o_ctl.band_adv   = 1'b0;
        o_ctl.step_adv   = 1'b0;
        o_ctl.active_nxt = i_active;
        o_ctl.await_nxt  = waiting;
        if (!waiting) begin
            if (i_pressed) begin
                o_ctl.load_start = !i_active;
                o_ctl.band_adv   = is_long;
                o_ctl.active_nxt = !is_long;
                o_ctl.await_nxt  = is_long;
            end else begin
                o_ctl.step_adv   = i_active && is_short;
                o_ctl.active_nxt = 1'b0;
            end
        end
    end

endmodule

// ===== hw/rtl/ebt_freq.sv =====
// ----------------------------------------------------------------------------
// ebt_freq
// tuning step with band clamp, and band advance with default load
// ----------------------------------------------------------------------------
module ebt_freq
    import ebt_pkg::*;
#(
    parameter int BAND_COUNT = BAND_COUNT_DEF
) (
    input  logic [FREQ_W-1:0] i_freq,
    input  logic [1:0]        i_band,
    input  logic [STEP_W-1:0] i_step_amt,
    input  t_quad_ctl         i_quad,
    input  logic              i_band_adv,
    output logic [FREQ_W-1:0] o_freq_nxt,
    output logic [1:0]        o_band_nxt
);

    localparam logic [1:0] BAND_LAST = 2'(BAND_COUNT - 1);

    logic [1:0]               sel;
    logic [1:0]               sel_nxt;
    logic signed [FREQ_W+1:0] f_ext;
    logic signed [FREQ_W+1:0] d_ext;
    logic signed [FREQ_W+1:0] f_sum;
    logic signed [FREQ_W+1:0] lo_ext;
    logic signed [FREQ_W+1:0] hi_ext;
    logic [FREQ_W-1:0]        f_clamp;
    logic [FREQ_W-1:0]        f_step;

    assign sel = (i_band <= BAND_LAST) ? i_band : 2'd0;

    // add or subtract the step, then clamp to the current band
    assign f_ext  = signed'({2'b00, i_freq});
    assign d_ext  = signed'({{(FREQ_W+2-STEP_W){1'b0}}, i_step_amt});
    assign f_sum  = i_quad.up ? f_ext + d_ext : f_ext - d_ext;
    assign lo_ext = signed'({2'b00, BAND_LO[sel]});
    assign hi_ext = signed'({2'b00, BAND_HI[sel]});

    always_comb begin
        if (f_sum < lo_ext) begin
            f_clamp = BAND_LO[sel];
        end else if (f_sum > hi_ext) begin
            f_clamp = BAND_HI[sel];
        end else begin
            f_clamp = f_sum[FREQ_W-1:0];
        end
    end

    assign f_step = i_quad.fire ? f_clamp : i_freq;

    // band advance wraps over the populated bands
    assign sel_nxt    = (sel == BAND_LAST) ? 2'd0 : sel + 2'd1;
    assign o_band_nxt = i_band_adv ? sel_nxt : i_band;
    assign o_freq_nxt = i_band_adv ? BAND_DFLT[sel_nxt] : f_step;

endmodule

// ===== hw/rtl/encoder_band_tuner_core.sv =====
// ----------------------------------------------------------------------------
// encoder_band_tuner_core
// encoder and push switch front end of a band limited frequency tuner
// ----------------------------------------------------------------------------
// a sample is held in the input register, its result in the result register
// throughput: one sample per cycle unless the output stalls; tuner state is
//   set in the same cycle the result loads, so the next sample sees it directly
// reset: synchronous, active low; clears tuner state and both stage valids,
//   and returns every configuration register to its default
`include "encoder_band_tuner_core_defines.svh"

module encoder_band_tuner_core
    import ebt_pkg::*;
#(
    parameter int BAND_COUNT = BAND_COUNT_DEF,
    parameter int STEP_COUNT = STEP_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ebt_in_if.sink               i_in,
    ebt_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam logic [1:0] STEP_LAST = 2'(STEP_COUNT - 1);

    // configuration
    logic [LP_W-1:0]   r_long_press;
    logic [DET_W-1:0]  r_detent;
    logic [STEP_W-1:0] r_step_small;
    logic [STEP_W-1:0] r_step_mid;
    logic [STEP_W-1:0] r_step_large;

    // tuner state
    logic [FREQ_W-1:0]        r_freq;
    logic [1:0]               r_band;
    logic [1:0]               r_step;
    logic [1:0]               r_last_pair;
    logic signed [CNT_W-1:0]  r_count;
    logic                     r_press_active;
    logic [TIME_W-1:0]        r_press_start;
    logic                     r_await;

    // pipeline registers
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    logic                    advance;
    logic                    in_ready;
    t_quad_ctl               quad;
    t_press_ctl              press;
    logic signed [CNT_W-1:0] n_count;
    logic [1:0]              n_last_pair;
    logic [FREQ_W-1:0]       n_freq;
    logic [1:0]              n_band;
    logic [1:0]              n_step;
    logic [STEP_W-1:0]       step_amt;
    t_out_item               n_out;

    assign advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign in_ready = !r_in_valid || advance;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press <= LONG_PRESS_RST;
            r_detent     <= DETENT_RST;
            r_step_small <= STEP_SMALL_RST;
            r_step_mid   <= STEP_MID_RST;
            r_step_large <= STEP_LARGE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LONG_PRESS: r_long_press <= i_cfg_data[LP_W-1:0];
                CFG_DETENT:     r_detent     <= i_cfg_data[DET_W-1:0];
                CFG_STEP_SMALL: r_step_small <= i_cfg_data[STEP_W-1:0];
                CFG_STEP_MID:   r_step_mid   <= i_cfg_data[STEP_W-1:0];
                CFG_STEP_LARGE: r_step_large <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_in.phase_a        <= i_in.phase_a;
            r_in.phase_b        <= i_in.phase_b;
            r_in.button_pressed <= i_in.button_pressed;
            r_in.now_ms         <= i_in.now_ms;
        end
    end

    // switch timing
    ebt_press u_press (
        .i_pressed    (r_in.button_pressed),
        .i_now        (r_in.now_ms),
        .i_active     (r_press_active),
        .i_start      (r_press_start),
        .i_await      (r_await),
        .i_long_press (r_long_press),
        .o_ctl        (press)
    );

    // encoder decode
    ebt_quad u_quad (
        .i_process   (press.process),
        .i_pair      ({r_in.phase_a, r_in.phase_b}),
        .i_last_pair (r_last_pair),
        .i_count     (r_count),
        .i_detent    (r_detent),
        .o_ctl       (quad),
        .o_count_nxt (n_count),
        .o_last_nxt  (n_last_pair)
    );

    // step amount for the current selection
    always_comb begin
        case (r_step)
            STEP_SEL_MID:   step_amt = r_step_mid;
            STEP_SEL_LARGE: step_amt = r_step_large;
            default:        step_amt = r_step_small;
        endcase
    end

    // frequency and band update
    ebt_freq #(
        .BAND_COUNT (BAND_COUNT)
    ) u_freq (
        .i_freq     (r_freq),
        .i_band     (r_band),
        .i_step_amt (step_amt),
        .i_quad     (quad),
        .i_band_adv (press.band_adv),
        .o_freq_nxt (n_freq),
        .o_band_nxt (n_band)
    );

    assign n_step = press.step_adv ?
                    ((r_step == STEP_LAST) ? STEP_SEL_SMALL : r_step + 2'd1) : r_step;

    // result assembly
    always_comb begin
        n_out.frequency_hz = n_freq;
        n_out.band_index   = n_band;
        n_out.step_select  = n_step;
        n_out.retune       = quad.fire || press.band_adv;
        n_out.redraw       = quad.fire || press.band_adv || press.step_adv;
    end

    // tuner state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq         <= BAND_DFLT[0];
            r_band         <= '0;
            r_step         <= STEP_SEL_SMALL;
            r_last_pair    <= '0;
            r_count        <= '0;
            r_press_active <= 1'b0;
            r_press_start  <= '0;
            r_await        <= 1'b0;
        end else if (advance) begin
            r_freq         <= n_freq;
            r_band         <= n_band;
            r_step         <= n_step;
            r_last_pair    <= n_last_pair;
            r_count        <= n_count;
            r_press_active <= press.active_nxt;
            r_await        <= press.await_nxt;
            if (press.load_start) begin
                r_press_start <= r_in.now_ms;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign i_in.ready         = in_ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.frequency_hz = r_out.frequency_hz;
    assign o_out.band_index   = r_out.band_index;
    assign o_out.step_select  = r_out.step_select;
    assign o_out.retune       = r_out.retune;
    assign o_out.redraw       = r_out.redraw;

    // checks
    `EBT_ASSERT_NOW(a_retune_redraw, r_out_valid && r_out.retune, r_out.redraw,
        "retune without redraw")
    `EBT_ASSERT_NOW(a_freq_in_band, r_out_valid,
        (r_out.frequency_hz >= BAND_LO[r_out.band_index]) &&
        (r_out.frequency_hz <= BAND_HI[r_out.band_index]), "frequency outside band")
    `EBT_ASSERT_NOW(a_await_idle, r_await, !r_press_active,
        "release wait with press still active")
    `EBT_ASSERT_NEXT(a_advance_out, advance, r_out_valid,
        "processed sample produced no result")

endmodule

// ===== bench/ebt_tuning_checker.sv =====
// ----------------------------------------------------------------------------
// ebt_tuning_checker
// watches the sample and result streams of the band tuner, keeps its own
// model of the tuner state and compares every result beat field by field
// ----------------------------------------------------------------------------
module ebt_tuning_checker
    import ebt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ebt_in_if                    i_in_mon,
    ebt_out_if                   i_out_mon,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_error_count,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // transition codes {old pair, new pair} that count up or down
    localparam logic [15:0] QUAD_UP_MASK = 16'b0100_0100_1000_0010;
    localparam logic [15:0] QUAD_DN_MASK = 16'b0010_1000_0001_0100;

    // register copies
    logic [LP_W-1:0]   hold_limit_ms;
    logic [DET_W-1:0]  detent_cfg;
    logic [STEP_W-1:0] size_small;
    logic [STEP_W-1:0] size_mid;
    logic [STEP_W-1:0] size_large;

    // tuner state copies
    logic [FREQ_W-1:0] freq_now;
    logic [1:0]        band_now;
    logic [1:0]        step_now;
    logic [1:0]        pair_last;
    int                detent_tally;
    logic              pressing;
    logic [TIME_W-1:0] press_t0;
    logic              hold_wait;

    t_out_item expected_readings[$];

    // advance the tuner copy by one sample and return the reading it shows
    function automatic t_out_item tune_sample(input t_in_item smp);
        logic [1:0]        pair;
        logic [3:0]        code;
        int                lim;
        longint            f;
        longint            delta;
        logic [TIME_W-1:0] elapsed;
        logic              retune;
        logic              redraw;
        t_out_item         r;
        pair   = {smp.phase_a, smp.phase_b};
        retune = 1'b0;
        redraw = 1'b0;

        // a release ends the wait after a long press and is processed as usual
        if (hold_wait && !smp.button_pressed)
            hold_wait = 1'b0;

        if (!hold_wait) begin
            // quadrature decode and detent step
            if (pair != pair_last) begin
                code = {pair_last, pair};
                lim  = (detent_cfg == '0) ? 1 : int'(detent_cfg);
                if (QUAD_UP_MASK[code])
                    detent_tally++;
                else if (QUAD_DN_MASK[code])
                    detent_tally--;
                pair_last = pair;
                if (detent_tally >= lim || detent_tally <= -lim) begin
                    case (step_now)
                        STEP_SEL_MID:   delta = longint'(size_mid);
                        STEP_SEL_LARGE: delta = longint'(size_large);
                        default:        delta = longint'(size_small);
                    endcase
                    f = longint'(freq_now) + ((detent_tally > 0) ? delta : -delta);
                    if (f < longint'(BAND_LO[band_now]))
                        f = longint'(BAND_LO[band_now]);
                    if (f > longint'(BAND_HI[band_now]))
                        f = longint'(BAND_HI[band_now]);
                    freq_now     = f[FREQ_W-1:0];
                    detent_tally = 0;
                    retune       = 1'b1;
                    redraw       = 1'b1;
                end
            end

            // switch timing
            if (smp.button_pressed) begin
                if (!pressing) begin
                    press_t0 = smp.now_ms;
                    pressing = 1'b1;
                end
                elapsed = smp.now_ms - press_t0;
                if (elapsed > TIME_W'(hold_limit_ms)) begin
                    band_now  = 2'((int'(band_now) + 1) % BAND_COUNT_DEF);
                    freq_now  = BAND_DFLT[band_now];
                    retune    = 1'b1;
                    redraw    = 1'b1;
                    pressing  = 1'b0;
                    hold_wait = 1'b1;
                end
            end else begin
                elapsed = smp.now_ms - press_t0;
                if (pressing && elapsed < TIME_W'(hold_limit_ms)) begin
                    step_now = 2'((int'(step_now) + 1) % STEP_COUNT_DEF);
                    redraw   = 1'b1;
                end
                pressing = 1'b0;
            end
        end

        r.frequency_hz = freq_now;
        r.band_index   = band_now;
        r.step_select  = step_now;
        r.retune       = retune;
        r.redraw       = redraw;
        return r;
    endfunction

    task automatic flag_field(input string field, input longint unsigned want,
                              input longint unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, field, want, got);
            o_error_count++;
        end
    endtask

    // register writes, sample beats and result beats, all on the rising edge
    always @(posedge i_clk) begin
        t_in_item  smp;
        t_out_item want;
        if (!i_rst_n) begin
            hold_limit_ms = LONG_PRESS_RST;
            detent_cfg    = DETENT_RST;
            size_small    = STEP_SMALL_RST;
            size_mid      = STEP_MID_RST;
            size_large    = STEP_LARGE_RST;
            freq_now      = BAND_DFLT[0];
            band_now      = '0;
            step_now      = STEP_SEL_SMALL;
            pair_last     = '0;
            detent_tally  = 0;
            pressing      = 1'b0;
            press_t0      = '0;
            hold_wait     = 1'b0;
            o_error_count = 0;
            expected_readings.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LONG_PRESS: hold_limit_ms = i_cfg_data[LP_W-1:0];
                    CFG_DETENT:     detent_cfg    = i_cfg_data[DET_W-1:0];
                    CFG_STEP_SMALL: size_small    = i_cfg_data[STEP_W-1:0];
                    CFG_STEP_MID:   size_mid      = i_cfg_data[STEP_W-1:0];
                    CFG_STEP_LARGE: size_large    = i_cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end

            if (i_in_mon.valid === 1'b1 && i_in_mon.ready === 1'b1) begin
                smp.phase_a        = i_in_mon.phase_a;
                smp.phase_b        = i_in_mon.phase_b;
                smp.button_pressed = i_in_mon.button_pressed;
                smp.now_ms         = i_in_mon.now_ms;
                expected_readings.push_back(tune_sample(smp));
            end

            if (i_out_mon.valid === 1'b1 && i_out_mon.ready === 1'b1) begin
                if (expected_readings.size() == 0) begin
                    $display("%0t ns: unexpected result beat, expected none, actual %0d hz",
                             $time, i_out_mon.frequency_hz);
                    o_error_count++;
                end else begin
                    want = expected_readings.pop_front();
                    flag_field("frequency_hz", want.frequency_hz, i_out_mon.frequency_hz);
                    flag_field("band_index", want.band_index, i_out_mon.band_index);
                    flag_field("step_select", want.step_select, i_out_mon.step_select);
                    flag_field("retune", want.retune, i_out_mon.retune);
                    flag_field("redraw", want.redraw, i_out_mon.redraw);
                end
            end
        end
        o_pending = expected_readings.size();
    end

endmodule

// ===== bench/encoder_band_tuner_core_test.sv =====
// ----------------------------------------------------------------------------
// encoder_band_tuner_core_test
// drives encoder and switch samples into the band tuner under several
// register settings: a directed pass over every phase transition and the
// press timing corners, then random rotation bursts, short, long and
// boundary presses and noise, with random gaps and output stalls
// ----------------------------------------------------------------------------
module encoder_band_tuner_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ebt_pkg::*;

    localparam int unsigned ITEM_TARGET = 1850;
    localparam int unsigned PHASE_ITEMS = 300;
    localparam int unsigned CYCLE_LIMIT = 400000;

    // visits every ordered pair of phase states once
    localparam logic [1:0] PAIR_TOUR [17] =
        '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3, 2'd0,
          2'd2, 2'd0, 2'd3, 2'd1, 2'd3, 2'd2, 2'd1, 2'd0};

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    int                   error_count;
    int                   pending;

    // stimulus state
    logic [1:0]  cur_pair = '0;
    logic        cur_btn = 1'b0;
    logic [31:0] clock_ms = '0;
    int unsigned hold_ms = 32'(LONG_PRESS_RST);
    int unsigned sent = 0;
    int unsigned cycles = 0;
    bit          steady_flow = 1'b0;

    ebt_in_if  in_ch ();
    ebt_out_if out_ch ();

    encoder_band_tuner_core u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    ebt_tuning_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_mon      (in_ch),
        .i_out_mon     (out_ch),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .o_error_count (error_count),
        .o_pending     (pending)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("encoder_band_tuner_core_test: errors");
            $finish;
        end
    end

    // result side: random stall before each beat, none in steady stretches
    initial begin
        int unsigned stall;
        out_ch.ready = 1'b0;
        forever begin
            stall = steady_flow ? 0 : $urandom_range(0, 15);
            repeat (stall) begin
                @(negedge clk);
                out_ch.ready <= 1'b0;
            end
            @(negedge clk);
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1));
        end
    end

    function automatic logic [1:0] gray_next(input logic [1:0] p, input bit up);
        case (p)
            2'd0:    return up ? 2'd1 : 2'd2;
            2'd1:    return up ? 2'd3 : 2'd0;
            2'd3:    return up ? 2'd2 : 2'd1;
            default: return up ? 2'd0 : 2'd3;
        endcase
    endfunction

    // one sample beat after a random gap
    task automatic send_sample();
        int unsigned gap;
        gap = steady_flow ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid          <= 1'b1;
        in_ch.phase_a        <= cur_pair[1];
        in_ch.phase_b        <= cur_pair[0];
        in_ch.button_pressed <= cur_btn;
        in_ch.now_ms         <= clock_ms;
        do @(posedge clk); while (!(in_ch.valid === 1'b1 && in_ch.ready === 1'b1));
        sent++;
    endtask

    task automatic turn(input bit up);
        cur_pair = gray_next(cur_pair, up);
        send_sample();
    endtask

    // wait until every sample has produced its result
    task automatic settle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
    endtask

    initial begin
        int unsigned kind;
        int unsigned n;
        int unsigned rel;
        int unsigned over;
        int unsigned phase;
        int unsigned phase_end;
        int unsigned total;
        int unsigned long_v;
        logic [CFG_W-1:0] det_v;
        logic [CFG_W-1:0] sm_v;
        logic [CFG_W-1:0] md_v;
        logic [CFG_W-1:0] lg_v;
        logic [31:0] t0;
        bit up;

        in_ch.valid          = 1'b0;
        in_ch.phase_a        = 1'b0;
        in_ch.phase_b        = 1'b0;
        in_ch.button_pressed = 1'b0;
        in_ch.now_ms         = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // every phase transition, timestamps running up to the top of the range
        clock_ms = 32'hFFFF_FFBB;
        for (int i = 0; i < 17; i++) begin
            cur_pair = PAIR_TOUR[i];
            clock_ms += 4;
            send_sample();
        end

        // short press released one ms before the long press time
        clock_ms = 32'd1000;
        cur_btn = 1'b1;
        send_sample();
        clock_ms += hold_ms - 1;
        cur_btn = 1'b0;
        send_sample();

        // release exactly at the long press time, timestamp wrapping
        clock_ms = 32'hFFFF_FEE0;
        cur_btn = 1'b1;
        send_sample();
        clock_ms += hold_ms;
        cur_btn = 1'b0;
        send_sample();

        // long press, encoder ignored while held, release processed
        clock_ms = 32'd5000;
        cur_btn = 1'b1;
        send_sample();
        clock_ms += hold_ms + 1;
        send_sample();
        clock_ms += 10;
        turn(1'b1);
        clock_ms += 10;
        cur_btn = 1'b0;
        turn(1'b1);

        total = sent + ITEM_TARGET;
        phase = 0;
        while (sent < total) begin
            // new register setting while idle
            settle();
            case (phase)
                0: begin
                    long_v = 1;
                    det_v  = 1;
                    sm_v   = 1;
                    md_v   = 20'hFFFFF;
                    lg_v   = 20'h80000;
                end
                1: begin
                    long_v = 16'hFFFF;
                    det_v  = 7;
                    sm_v   = 20'hFFFFF;
                    md_v   = 1;
                    lg_v   = 5000;
                end
                2: begin
                    long_v = 0;
                    det_v  = 0;
                    sm_v   = 0;
                    md_v   = CFG_W'($urandom_range(1, 20'hFFFFF));
                    lg_v   = 20'hFFFFF;
                end
                default: begin
                    long_v = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535)
                                                         : $urandom_range(1, 1500);
                    det_v  = CFG_W'($urandom_range(0, 7));
                    sm_v   = CFG_W'($urandom_range(0, 1) ? $urandom_range(1, 20'hFFFFF)
                                                         : $urandom_range(1, 50000));
                    md_v   = CFG_W'($urandom_range(0, 1) ? $urandom_range(1, 20'hFFFFF)
                                                         : $urandom_range(1, 50000));
                    lg_v   = CFG_W'($urandom_range(0, 1) ? $urandom_range(1, 20'hFFFFF)
                                                         : $urandom_range(1, 50000));
                end
            endcase
            cfg_write(CFG_LONG_PRESS, CFG_W'(long_v));
            cfg_write(CFG_DETENT, det_v);
            cfg_write(CFG_STEP_SMALL, sm_v);
            cfg_write(CFG_STEP_MID, md_v);
            cfg_write(CFG_STEP_LARGE, lg_v);
            @(negedge clk);
            cfg_we <= 1'b0;
            hold_ms = long_v;
            steady_flow = ($urandom_range(0, 3) == 0);
            phase_end = sent + PHASE_ITEMS;
            phase++;

            while (sent < phase_end && sent < total) begin
                if ($urandom_range(0, 19) == 0)
                    steady_flow = !steady_flow;
                // now and then start near the top of the timestamp range
                if ($urandom_range(0, 15) == 0)
                    clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
                up = 1'($urandom_range(0, 1));
                kind = $urandom_range(0, 9);
                case (kind)
                    // rotation burst with the odd reversal and phase glitch
                    0, 1, 2, 3, 4: begin
                        n = $urandom_range(1, 12);
                        repeat (n) begin
                            clock_ms += $urandom_range(0, 20);
                            if ($urandom_range(0, 9) == 0) begin
                                cur_pair = 2'($urandom_range(0, 3));
                                send_sample();
                            end else begin
                                if ($urandom_range(0, 7) == 0)
                                    up = !up;
                                turn(up);
                            end
                        end
                    end
                    // short press, turning while held
                    5, 6: begin
                        t0 = clock_ms;
                        rel = (hold_ms == 0) ? 0 : $urandom_range(0, hold_ms - 1);
                        cur_btn = 1'b1;
                        send_sample();
                        n = $urandom_range(0, 4);
                        for (int j = 1; j <= int'(n); j++) begin
                            clock_ms = t0 + rel * j / (n + 1);
                            turn(up);
                        end
                        clock_ms = t0 + rel;
                        cur_btn = 1'b0;
                        send_sample();
                    end
                    // long press with turns while held, then turns that must be ignored, then release
                    7: begin
                        t0 = clock_ms;
                        over = hold_ms + $urandom_range(1, 300);
                        cur_btn = 1'b1;
                        send_sample();
                        n = $urandom_range(1, 4);
                        for (int j = 1; j <= int'(n); j++) begin
                            clock_ms = t0 + over * j / n;
                            turn(up);
                        end
                        repeat ($urandom_range(0, 3)) begin
                            clock_ms += $urandom_range(0, 50);
                            turn(up);
                        end
                        clock_ms += $urandom_range(0, 50);
                        cur_btn = 1'b0;
                        turn(up);
                    end
                    // release exactly at the long press time
                    8: begin
                        t0 = clock_ms;
                        cur_btn = 1'b1;
                        send_sample();
                        clock_ms = t0 + hold_ms;
                        cur_btn = 1'b0;
                        send_sample();
                    end
                    // noise: any pair, any switch level, any timestamp
                    default: begin
                        cur_pair = 2'($urandom_range(0, 3));
                        cur_btn  = 1'($urandom_range(0, 1));
                        clock_ms = $urandom;
                        send_sample();
                        if (cur_btn) begin
                            clock_ms += $urandom_range(0, 2000);
                            cur_btn = 1'b0;
                            send_sample();
                        end
                    end
                endcase
            end
        end

        settle();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("encoder_band_tuner_core_test: clean");
        else
            $display("encoder_band_tuner_core_test: errors");
        $finish;
    end

endmodule

// ===== encoder_band_tuner_core.f =====
+incdir+hw/rtl
hw/rtl/ebt_pkg.sv
hw/rtl/ebt_ifs.sv
hw/rtl/ebt_quad.sv
hw/rtl/ebt_press.sv
hw/rtl/ebt_freq.sv
hw/rtl/encoder_band_tuner_core.sv
bench/ebt_tuning_checker.sv
bench/encoder_band_tuner_core_test.sv
